>>> hdl/assert_macros.svh
// assertion macros used by mwct_ctrl of the watch condition table
// no dependencies; include by bare file name inside a module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MWCT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising clock edge, reset included
`define MWCT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/mwct_pkg.sv
// shared types, codes and sizes of the watch condition table
// no dependencies; imported by every module of the block
`default_nettype none

package mwct_pkg;

   // table size and derived widths
   localparam int ENTRIES = 128;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int SUM_W   = CNT_W + 1;

   // request commands
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_START  = 2'd2;
   localparam logic [1:0] CMD_DATA   = 2'd3;

   // condition kinds
   localparam logic [1:0] KIND_EQ  = 2'd0;
   localparam logic [1:0] KIND_NE  = 2'd1;
   localparam logic [1:0] KIND_CH  = 2'd2;
   localparam logic [1:0] KIND_BAD = 2'd3;

   // response kinds
   localparam logic [1:0] RK_STATUS = 2'd0;
   localparam logic [1:0] RK_READ   = 2'd1;
   localparam logic [1:0] RK_DONE   = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_DUP        = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_BADKIND    = 3'd3;
   localparam logic [2:0] ST_NOTFOUND   = 3'd4;
   localparam logic [2:0] ST_UNEXPECTED = 3'd5;
   localparam logic [2:0] ST_BUSY       = 3'd6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_SHIFT,
      S_EVAL,
      S_ADDR,
      S_EMIT
   } state_type;

   // one table entry
   typedef struct packed {
      logic [15:0] addr;
      logic [15:0] refv;
      logic [1:0]  kind;
   } entry_type;

   // table port control
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      entry_type        wr_data;
      logic [IDX_W-1:0] rd_idx;
   } ram_req_type;

   // one response item
   typedef struct packed {
      logic [1:0]  result_kind;
      logic [2:0]  status;
      logic [15:0] read_addr;
      logic        hit;
   } result_type;

   // response handed to the output register
   typedef struct packed {
      logic       valid;
      result_type result;
   } emit_type;

endpackage

`default_nettype wire

>>> hdl/mwct_ram.sv
// condition table storage: one write port, one registered read port
// depends on mwct_pkg
`default_nettype none

module mwct_ram (
   input  wire logic                 clock,
   input  wire mwct_pkg::ram_req_type ram_req,
   output mwct_pkg::entry_type       rd_data
);
   import mwct_pkg::*;

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_idx] <= ram_req.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[ram_req.rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/mwct_ctrl.sv
// sequencer of the watch condition table: scan, shift, check walk,
// one shared 16-bit equality compare; depends on mwct_pkg, assert_macros.svh
`default_nettype none

module mwct_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_command,
   input  wire logic [15:0]           req_watch_addr,
   input  wire logic [1:0]            req_cond_kind,
   input  wire logic [15:0]           req_ref_value,
   input  wire logic [15:0]           req_mem_data,
   input  wire logic                  out_free,
   output mwct_pkg::emit_type         emit,
   output mwct_pkg::ram_req_type      ram_req,
   input  wire mwct_pkg::entry_type   rd_data
);
   import mwct_pkg::*;
   `include "assert_macros.svh"

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             checking_ff, checking_in;
   logic [IDX_W-1:0] check_idx_ff, check_idx_in;

   // captured request and pending response
   logic [1:0]  cmd_ff, cmd_in;
   logic [15:0] key_ff, key_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] refv_ff, refv_in;
   logic [15:0] data_ff, data_in;
   result_type  res_ff, res_in;

   // derived conditions
   logic [SUM_W-1:0] idx_p1, idx_p2, chk_next, count_w;
   logic             scan_more, shift_more, chk_more;
   logic [15:0]      cmp_a, cmp_b;
   logic             cmp_eq;
   logic             holds;
   logic             add_full, add_ok;
   logic [2:0]       add_status;

   function automatic result_type mk_result(logic [1:0] rk, logic [2:0] st,
                                            logic [15:0] ra, logic h);
      result_type r;
      r.result_kind = rk;
      r.status      = st;
      r.read_addr   = ra;
      r.hit         = h;
      return r;
   endfunction

   // index arithmetic
   assign count_w    = SUM_W'(count_ff);
   assign idx_p1     = SUM_W'(idx_ff) + SUM_W'(1);
   assign idx_p2     = SUM_W'(idx_ff) + SUM_W'(2);
   assign chk_next   = SUM_W'(check_idx_ff) + SUM_W'(1);
   assign scan_more  = idx_p1 < count_w;
   assign shift_more = idx_p2 < count_w;
   assign chk_more   = chk_next < count_w;

   // shared compare unit: address match in scan, reference match in check
   assign cmp_a  = (state_ff == S_EVAL) ? rd_data.refv : rd_data.addr;
   assign cmp_b  = (state_ff == S_EVAL) ? data_ff : key_ff;
   assign cmp_eq = (cmp_a == cmp_b);

   // condition test of the entry under check
   always_comb begin
      case (rd_data.kind)
         KIND_EQ: holds = cmp_eq;
         KIND_NE: holds = !cmp_eq;
         KIND_CH: holds = !cmp_eq;
         default: holds = 1'b0;
      endcase
   end

   // add outcome once no duplicate was found
   assign add_full   = (count_ff == CNT_W'(ENTRIES));
   assign add_ok     = !add_full && (kind_ff != KIND_BAD);
   assign add_status = add_full ? ST_FULL : ((kind_ff == KIND_BAD) ? ST_BADKIND : ST_OK);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (cmd_ff == CMD_DATA) begin
               state_in = checking_ff ? S_EVAL : S_EMIT;
            end else if (checking_ff) begin
               state_in = S_EMIT;
            end else if (count_ff == '0) begin
               state_in = S_EMIT;
            end else if (cmd_ff == CMD_START) begin
               state_in = S_ADDR;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cmp_eq) begin
               state_in = (cmd_ff == CMD_REMOVE && scan_more) ? S_SHIFT : S_EMIT;
            end else begin
               state_in = scan_more ? S_SCAN : S_EMIT;
            end
         end
         S_SHIFT: begin
            state_in = shift_more ? S_SHIFT : S_EMIT;
         end
         S_EVAL: begin
            state_in = (holds || !chk_more) ? S_EMIT : S_ADDR;
         end
         S_ADDR: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      count_in       = count_ff;
      idx_in         = idx_ff;
      checking_in    = checking_ff;
      check_idx_in   = check_idx_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      kind_in        = kind_ff;
      refv_in        = refv_ff;
      data_in        = data_ff;
      res_in         = res_ff;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_idx  = idx_ff[IDX_W-1:0];
      ram_req.wr_data = rd_data;
      ram_req.rd_idx  = idx_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            // capture the request on transfer
            if (req_valid) begin
               cmd_in  = req_command;
               key_in  = req_watch_addr;
               kind_in = req_cond_kind;
               refv_in = req_ref_value;
               data_in = req_mem_data;
            end
         end
         S_DISPATCH: begin
            idx_in         = '0;
            ram_req.rd_idx = '0;
            if (cmd_ff == CMD_DATA) begin
               if (checking_ff) begin
                  ram_req.rd_idx = check_idx_ff;
               end else begin
                  res_in = mk_result(RK_STATUS, ST_UNEXPECTED, 16'd0, 1'b0);
               end
            end else if (checking_ff) begin
               res_in = mk_result(RK_STATUS, ST_BUSY, 16'd0, 1'b0);
            end else begin
               case (cmd_ff)
                  CMD_ADD: begin
                     // empty table: nothing to scan
                     if (count_ff == '0) begin
                        res_in          = mk_result(RK_STATUS, add_status, 16'd0, 1'b0);
                        ram_req.wr_en   = add_ok;
                        ram_req.wr_idx  = count_ff[IDX_W-1:0];
                        ram_req.wr_data = '{addr: key_ff, refv: refv_ff, kind: kind_ff};
                        if (add_ok) count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        res_in = mk_result(RK_STATUS, ST_NOTFOUND, 16'd0, 1'b0);
                     end
                  end
                  default: begin
                     // start check
                     if (count_ff == '0) begin
                        res_in = mk_result(RK_DONE, ST_OK, 16'd0, 1'b0);
                     end else begin
                        checking_in  = 1'b1;
                        check_idx_in = '0;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (cmp_eq) begin
               if (cmd_ff == CMD_ADD) begin
                  res_in = mk_result(RK_STATUS, ST_DUP, 16'd0, 1'b0);
               end else if (scan_more) begin
                  ram_req.rd_idx = idx_p1[IDX_W-1:0];
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  res_in   = mk_result(RK_STATUS, ST_OK, 16'd0, 1'b0);
               end
            end else if (scan_more) begin
               idx_in         = CNT_W'(idx_p1);
               ram_req.rd_idx = idx_p1[IDX_W-1:0];
            end else if (cmd_ff == CMD_ADD) begin
               res_in          = mk_result(RK_STATUS, add_status, 16'd0, 1'b0);
               ram_req.wr_en   = add_ok;
               ram_req.wr_idx  = count_ff[IDX_W-1:0];
               ram_req.wr_data = '{addr: key_ff, refv: refv_ff, kind: kind_ff};
               if (add_ok) count_in = count_ff + CNT_W'(1);
            end else begin
               res_in = mk_result(RK_STATUS, ST_NOTFOUND, 16'd0, 1'b0);
            end
         end
         S_SHIFT: begin
            // move entry idx+1 down to idx
            ram_req.wr_en = 1'b1;
            if (shift_more) begin
               idx_in         = CNT_W'(idx_p1);
               ram_req.rd_idx = idx_p2[IDX_W-1:0];
            end else begin
               count_in = count_ff - CNT_W'(1);
               res_in   = mk_result(RK_STATUS, ST_OK, 16'd0, 1'b0);
            end
         end
         S_EVAL: begin
            // changed entry takes the new word as reference
            ram_req.wr_idx  = check_idx_ff;
            ram_req.wr_data = '{addr: rd_data.addr, refv: data_ff, kind: rd_data.kind};
            ram_req.wr_en   = (rd_data.kind == KIND_CH) && !cmp_eq;
            if (holds || !chk_more) begin
               checking_in  = 1'b0;
               check_idx_in = '0;
               res_in       = mk_result(RK_DONE, ST_OK, 16'd0, holds);
            end else begin
               check_idx_in   = chk_next[IDX_W-1:0];
               ram_req.rd_idx = chk_next[IDX_W-1:0];
            end
         end
         S_ADDR: begin
            res_in = mk_result(RK_READ, ST_OK, rd_data.addr, 1'b0);
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         checking_ff  <= 1'b0;
         check_idx_ff <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         checking_ff  <= checking_in;
         check_idx_ff <= check_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      key_ff  <= key_in;
      kind_ff <= kind_in;
      refv_ff <= refv_in;
      data_ff <= data_in;
      res_ff  <= res_in;
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign emit.valid   = (state_ff == S_EMIT);
   assign emit.result  = res_ff;

   // checks
   `MWCT_ASSERT(a_check_idx_in_range, clock, reset,
      checking_ff |-> (SUM_W'(check_idx_ff) < count_w), "check index beyond table fill")
   `MWCT_ASSERT(a_count_frozen_in_check, clock, reset,
      (checking_ff && $past(checking_ff)) |-> $stable(count_ff), "table fill changed during check")
   `MWCT_ASSERT(a_write_only_when_busy, clock, reset,
      ram_req.wr_en |-> (state_ff != S_IDLE && state_ff != S_EMIT), "table write outside a command")
   `MWCT_ASSERT(a_count_bounded, clock, reset,
      (count_ff != $past(count_ff)) |-> (state_ff == S_EMIT), "fill changed without a response")

endmodule

`default_nettype wire

>>> hdl/memory_watch_condition_table.sv
// Throughput: one request at a time; the next transfer is taken in the cycle after the response
// is registered; the single read port walks one entry per cycle in a scan or shift.
// Reset: synchronous, clears fill count and check state; table contents stay undefined
// until written, with no clearing pass.
`default_nettype none

module memory_watch_condition_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_watch_addr,
   input  wire logic [1:0]  req_cond_kind,
   input  wire logic [15:0] req_ref_value,
   input  wire logic [15:0] req_mem_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_read_addr,
   output logic             rsp_hit
);
   import mwct_pkg::*;

   emit_type    emit;
   ram_req_type ram_req;
   entry_type   rd_data;
   logic        out_free;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   mwct_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_watch_addr (req_watch_addr),
      .req_cond_kind  (req_cond_kind),
      .req_ref_value  (req_ref_value),
      .req_mem_data   (req_mem_data),
      .out_free       (out_free),
      .emit           (emit),
      .ram_req        (ram_req),
      .rd_data        (rd_data)
   );

   mwct_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // output register: free when empty or being transferred
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = emit.valid;
         if (emit.valid) rsp_in = emit.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_ff.result_kind;
   assign rsp_status      = rsp_ff.status;
   assign rsp_read_addr   = rsp_ff.read_addr;
   assign rsp_hit         = rsp_ff.hit;

endmodule

`default_nettype wire

>>> tb/tb_memory_watch_condition_table.sv
// self-checking testbench for memory_watch_condition_table: a shadow of the
// condition table predicts each response, random traffic drives both channels
// depends on mwct_pkg and the memory_watch_condition_table rtl
`default_nettype none

module tb_memory_watch_condition_table;
   import mwct_pkg::*;

   // traffic styles for the random phases
   localparam int STYLE_MIX   = 0;
   localparam int STYLE_FILL  = 1;
   localparam int STYLE_DRAIN = 2;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 240;
   localparam int POOL        = 48;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_WAIT  = 300;

   // shadow of the condition table; predicts and checks every response
   class condition_tracker;
      logic [15:0] tbl_addr [ENTRIES];
      logic [15:0] tbl_ref  [ENTRIES];
      logic [1:0]  tbl_kind [ENTRIES];
      int          fill;
      bit          walking;
      int          walk_idx;
      result_type  due_responses [$];
      int          errors;
      int          requests;
      int          responses;
      int          hit_count;
      int          full_count;
      int          peak_fill;

      function result_type make_result(logic [1:0] rk, logic [2:0] st,
                                       logic [15:0] a, logic h);
         result_type r;
         r.result_kind = rk;
         r.status      = st;
         r.read_addr   = a;
         r.hit         = h;
         return r;
      endfunction

      function int find_addr(logic [15:0] a);
         for (int i = 0; i < fill; i++) begin
            if (tbl_addr[i] == a) return i;
         end
         return fill;
      endfunction

      // next response of the table for one request, updating the shadow
      function result_type table_response(logic [1:0] cmd, logic [15:0] addr,
                                          logic [1:0] kind, logic [15:0] refv,
                                          logic [15:0] data);
         int pos;
         bit holds;
         // memory word returned during a walk
         if (cmd == CMD_DATA) begin
            if (!walking || walk_idx >= fill)
               return make_result(RK_STATUS, ST_UNEXPECTED, 16'd0, 1'b0);
            holds = 1'b0;
            case (tbl_kind[walk_idx])
               KIND_EQ: holds = (data == tbl_ref[walk_idx]);
               KIND_NE: holds = (data != tbl_ref[walk_idx]);
               KIND_CH: begin
                  if (data != tbl_ref[walk_idx]) begin
                     tbl_ref[walk_idx] = data;
                     holds = 1'b1;
                  end
               end
               default: holds = 1'b0;
            endcase
            if (holds) begin
               walking  = 1'b0;
               walk_idx = 0;
               hit_count++;
               return make_result(RK_DONE, ST_OK, 16'd0, 1'b1);
            end
            walk_idx++;
            if (walk_idx >= fill) begin
               walking  = 1'b0;
               walk_idx = 0;
               return make_result(RK_DONE, ST_OK, 16'd0, 1'b0);
            end
            return make_result(RK_READ, ST_OK, tbl_addr[walk_idx], 1'b0);
         end
         if (walking) return make_result(RK_STATUS, ST_BUSY, 16'd0, 1'b0);
         // add: duplicate, then full, then bad kind
         if (cmd == CMD_ADD) begin
            if (find_addr(addr) != fill) return make_result(RK_STATUS, ST_DUP, 16'd0, 1'b0);
            if (fill >= ENTRIES) begin
               full_count++;
               return make_result(RK_STATUS, ST_FULL, 16'd0, 1'b0);
            end
            if (kind == KIND_BAD) return make_result(RK_STATUS, ST_BADKIND, 16'd0, 1'b0);
            tbl_addr[fill] = addr;
            tbl_ref[fill]  = refv;
            tbl_kind[fill] = kind;
            fill++;
            if (fill > peak_fill) peak_fill = fill;
            return make_result(RK_STATUS, ST_OK, 16'd0, 1'b0);
         end
         // remove closes the gap
         if (cmd == CMD_REMOVE) begin
            pos = find_addr(addr);
            if (pos >= fill) return make_result(RK_STATUS, ST_NOTFOUND, 16'd0, 1'b0);
            for (int i = pos; i + 1 < fill; i++) begin
               tbl_addr[i] = tbl_addr[i + 1];
               tbl_ref[i]  = tbl_ref[i + 1];
               tbl_kind[i] = tbl_kind[i + 1];
            end
            fill--;
            return make_result(RK_STATUS, ST_OK, 16'd0, 1'b0);
         end
         // start of a walk
         if (fill == 0) return make_result(RK_DONE, ST_OK, 16'd0, 1'b0);
         walking  = 1'b1;
         walk_idx = 0;
         return make_result(RK_READ, ST_OK, tbl_addr[0], 1'b0);
      endfunction

      function void note_request(logic [1:0] cmd, logic [15:0] addr, logic [1:0] kind,
                                 logic [15:0] refv, logic [15:0] data);
         requests++;
         due_responses.push_back(table_response(cmd, addr, kind, refv, data));
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (due_responses.size() == 0) begin
            errors++;
            $display("%0t: response with none due, expected nothing actual kind %0d status %0d",
                     $time, got.result_kind, got.status);
            return;
         end
         want = due_responses.pop_front();
         responses++;
         compare_field("result_kind", want.result_kind, got.result_kind);
         compare_field("status", want.status, got.status);
         compare_field("read_addr", want.read_addr, got.read_addr);
         compare_field("hit", want.hit, got.hit);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire logic   req_stall;
   logic [1:0]  req_command = CMD_ADD;
   logic [15:0] req_watch_addr = 16'd0;
   logic [1:0]  req_cond_kind = KIND_EQ;
   logic [15:0] req_ref_value = 16'd0;
   logic [15:0] req_mem_data = 16'd0;
   wire logic   rsp_valid;
   logic        rsp_stall = 1'b0;
   wire logic [1:0]  rsp_result_kind;
   wire logic [2:0]  rsp_status;
   wire logic [15:0] rsp_read_addr;
   wire logic        rsp_hit;

   condition_tracker tracker;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_requests = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   bit          miss_walk = 1'b0;
   logic [15:0] addr_pool [POOL];

   memory_watch_condition_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_watch_addr  (req_watch_addr),
      .req_cond_kind   (req_cond_kind),
      .req_ref_value   (req_ref_value),
      .req_mem_data    (req_mem_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_status      (rsp_status),
      .rsp_read_addr   (rsp_read_addr),
      .rsp_hit         (rsp_hit)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // response side: check each transfer, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            tracker.check_response({rsp_result_kind, rsp_status, rsp_read_addr, rsp_hit});
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // offer one request and wait for its transfer
   task automatic send_request(input logic [1:0] cmd, input logic [15:0] addr,
                               input logic [1:0] kind, input logic [15:0] refv,
                               input logic [15:0] data);
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_watch_addr <= addr;
      req_cond_kind  <= kind;
      req_ref_value  <= refv;
      req_mem_data   <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(cmd, addr, kind, refv, data);
   endtask

   // random idle stretch between requests
   task automatic sender_gap();
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // next random request; mostly well-formed walks, some noise
   task automatic make_item(input int style, output logic [1:0] cmd,
                            output logic [15:0] addr, output logic [1:0] kind,
                            output logic [15:0] refv, output logic [15:0] data);
      int roll;
      int add_w;
      int rem_w;
      int start_w;
      logic [15:0] cur_ref;
      logic [1:0]  cur_kind;
      addr = 16'($urandom);
      kind = 2'($urandom_range(2));
      refv = 16'($urandom);
      data = 16'($urandom);
      if ($urandom_range(99) < 45) addr = addr_pool[$urandom_range(POOL - 1)];
      roll = $urandom_range(99);
      if (tracker.walking) begin
         // supply the word for the pending read, or poke a busy command
         if (roll < 88) begin
            cmd      = CMD_DATA;
            cur_ref  = tracker.tbl_ref[tracker.walk_idx];
            cur_kind = tracker.tbl_kind[tracker.walk_idx];
            if (miss_walk || roll < 35)
               data = (cur_kind == KIND_EQ) ? cur_ref + 16'd1 : cur_ref;
            else if (roll < 60)
               data = cur_ref;
         end else begin
            cmd = 2'($urandom_range(2));
         end
      end else begin
         case (style)
            STYLE_FILL: begin
               add_w = 85; rem_w = 3; start_w = 7;
            end
            STYLE_DRAIN: begin
               add_w = 12; rem_w = 63; start_w = 20;
            end
            default: begin
               add_w = 38; rem_w = 22; start_w = 35;
            end
         endcase
         if (roll < add_w) cmd = CMD_ADD;
         else if (roll < add_w + rem_w) cmd = CMD_REMOVE;
         else if (roll < add_w + rem_w + start_w) cmd = CMD_START;
         else cmd = CMD_DATA;
         if (cmd == CMD_ADD && $urandom_range(99) < 8) kind = KIND_BAD;
         if (cmd == CMD_REMOVE && tracker.fill > 0 && $urandom_range(99) < 70)
            addr = tracker.tbl_addr[$urandom_range(tracker.fill - 1)];
         if (cmd == CMD_START)
            miss_walk = ($urandom_range(99) < ((tracker.fill > 16) ? 6 : 30));
      end
   endtask

   // stimulus
   initial begin
      int style_of [PHASES];
      int idle_of [PHASES];
      int stall_of [PHASES];
      logic [1:0]  cmd;
      logic [15:0] addr;
      logic [1:0]  kind;
      logic [15:0] refv;
      logic [15:0] data;
      tracker = new();
      style_of = '{STYLE_MIX, STYLE_FILL, STYLE_MIX, STYLE_FILL,
                   STYLE_DRAIN, STYLE_MIX, STYLE_FILL, STYLE_DRAIN};
      idle_of  = '{0, 72, 0, 23, 0, 72, 0, 23};
      stall_of = '{0, 0, 72, 23, 0, 0, 72, 23};
      addr_pool[0] = 16'h0000;
      addr_pool[1] = 16'hFFFF;
      for (int i = 2; i < POOL; i++) addr_pool[i] = 16'($urandom);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: edge cases on an almost empty table
      send_request(CMD_DATA,   16'h0000, KIND_EQ,  16'h0000, 16'hFFFF); // data while idle
      send_request(CMD_START,  16'hFFFF, KIND_EQ,  16'hFFFF, 16'h0000); // empty table walk
      send_request(CMD_REMOVE, 16'h0000, KIND_EQ,  16'h0000, 16'h0000); // absent address
      send_request(CMD_ADD,    16'h0000, KIND_EQ,  16'h0000, 16'hFFFF);
      send_request(CMD_ADD,    16'hFFFF, KIND_NE,  16'hFFFF, 16'h0000);
      send_request(CMD_ADD,    16'h1234, KIND_CH,  16'h5555, 16'hAAAA);
      send_request(CMD_ADD,    16'h0000, KIND_EQ,  16'h0001, 16'h0000); // duplicate
      send_request(CMD_ADD,    16'h0777, KIND_BAD, 16'h0000, 16'h0000); // bad kind
      send_request(CMD_ADD,    16'hFFFF, KIND_BAD, 16'h0000, 16'h0000); // duplicate wins
      send_request(CMD_START,  16'h0000, KIND_EQ,  16'h0000, 16'h0000);
      send_request(CMD_ADD,    16'h0AAA, KIND_EQ,  16'h0000, 16'h0000); // busy
      send_request(CMD_REMOVE, 16'h0000, KIND_EQ,  16'h0000, 16'h0000); // busy
      send_request(CMD_START,  16'h0000, KIND_EQ,  16'h0000, 16'h0000); // busy
      send_request(CMD_DATA,   16'h0000, KIND_EQ,  16'h0000, 16'h0001);
      send_request(CMD_DATA,   16'h0000, KIND_EQ,  16'h0000, 16'hFFFF);
      send_request(CMD_DATA,   16'h0000, KIND_EQ,  16'h0000, 16'h5555); // walk ends, no hit
      send_request(CMD_START,  16'h0000, KIND_EQ,  16'h0000, 16'h0000);
      send_request(CMD_DATA,   16'h0000, KIND_EQ,  16'h0000, 16'h0000); // equal holds
      send_request(CMD_REMOVE, 16'hFFFF, KIND_EQ,  16'h0000, 16'h0000); // middle entry
      send_request(CMD_START,  16'h0000, KIND_EQ,  16'h0000, 16'h0000);
      send_request(CMD_DATA,   16'h0000, KIND_EQ,  16'h0000, 16'h0001);
      send_request(CMD_DATA,   16'h0000, KIND_EQ,  16'h0000, 16'h6666); // changed holds
      send_request(CMD_START,  16'h0000, KIND_EQ,  16'h0000, 16'h0000);
      send_request(CMD_DATA,   16'h0000, KIND_EQ,  16'h0000, 16'h0002);
      send_request(CMD_DATA,   16'h0000, KIND_EQ,  16'h0000, 16'h6666); // new reference kept
      req_valid <= 1'b0;
      while (tracker.due_responses.size() != 0) @(posedge clock);

      // random phases under different idle and stall mixes
      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = idle_of[p];
         stall_pct     = stall_of[p];
         if (p == 2) hold_requests++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            make_item(style_of[p], cmd, addr, kind, refv, data);
            send_request(cmd, addr, kind, refv, data);
            sender_gap();
         end
         // pause until every response of the phase is back
         req_valid <= 1'b0;
         while (tracker.due_responses.size() != 0) @(posedge clock);
      end

      // trailing window for stray responses
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d request transfers and %0d response transfers, %0d walks hit",
               tracker.requests, tracker.responses, tracker.hit_count);
      $display("table fill peaked at %0d of %0d, %0d adds met a full table",
               tracker.peak_fill, ENTRIES, tracker.full_count);
      if (tracker.errors == 0 && tracker.due_responses.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // run limit
   initial begin
      #20000000;
      $display("timeout with %0d responses still due", tracker.due_responses.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
